/* src/qtg_pkg.sv */
// Shared types and constants for the quintic trajectory generator.
// Holds the Horner operation table used by the evaluation engine.
// No dependencies.
package qtg_pkg;

  localparam int NumCoefs  = 6;
  localparam int NumOps    = 18;
  localparam int OpW       = 5;
  localparam int CoefW     = 32;
  localparam int TimeW     = 24;
  localparam int StepW     = 16;
  localparam int FracW     = 16;
  localparam int CfgIdxW   = 3;
  localparam int WeightW   = 6;
  localparam int TermW     = 38;
  localparam int ProdW     = 57;
  localparam int SumW      = 42;

  typedef logic signed [CoefW-1:0] qtg_coef_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_0    = 3'd0,
    REG_COEF_1    = 3'd1,
    REG_COEF_2    = 3'd2,
    REG_COEF_3    = 3'd3,
    REG_COEF_4    = 3'd4,
    REG_COEF_5    = 3'd5,
    REG_TIME_STEP = 3'd6,
    REG_END_TIME  = 3'd7
  } qtg_reg_e;

  typedef enum logic [1:0] {
    POLY_POS = 2'd0,
    POLY_VEL = 2'd1,
    POLY_ACC = 2'd2,
    POLY_JRK = 2'd3
  } qtg_poly_e;

  // one queued tick: the time it evaluates and whether it wraps afterwards
  typedef struct packed {
    logic [TimeW-1:0] sample_time;
    logic             last;
  } qtg_item_t;

  typedef struct packed {
    logic               init;
    logic               fin;
    qtg_poly_e          poly;
    logic [2:0]         cidx;
    logic [WeightW-1:0] weight;
  } qtg_op_t;

  function automatic qtg_op_t mk_op(input logic init, input logic fin, input qtg_poly_e poly,
                                    input logic [2:0] cidx, input logic [WeightW-1:0] weight);
    qtg_op_t r;
    r.init   = init;
    r.fin    = fin;
    r.poly   = poly;
    r.cidx   = cidx;
    r.weight = weight;
    return r;
  endfunction

  // Horner schedule: each polynomial starts at its top coefficient
  function automatic qtg_op_t op_info(input logic [OpW-1:0] op);
    qtg_op_t r;
    case (op)
      5'd0:    r = mk_op(1'b1, 1'b0, POLY_POS, 3'd5, 6'd1);
      5'd1:    r = mk_op(1'b0, 1'b0, POLY_POS, 3'd4, 6'd1);
      5'd2:    r = mk_op(1'b0, 1'b0, POLY_POS, 3'd3, 6'd1);
      5'd3:    r = mk_op(1'b0, 1'b0, POLY_POS, 3'd2, 6'd1);
      5'd4:    r = mk_op(1'b0, 1'b0, POLY_POS, 3'd1, 6'd1);
      5'd5:    r = mk_op(1'b0, 1'b1, POLY_POS, 3'd0, 6'd1);
      5'd6:    r = mk_op(1'b1, 1'b0, POLY_VEL, 3'd5, 6'd5);
      5'd7:    r = mk_op(1'b0, 1'b0, POLY_VEL, 3'd4, 6'd4);
      5'd8:    r = mk_op(1'b0, 1'b0, POLY_VEL, 3'd3, 6'd3);
      5'd9:    r = mk_op(1'b0, 1'b0, POLY_VEL, 3'd2, 6'd2);
      5'd10:   r = mk_op(1'b0, 1'b1, POLY_VEL, 3'd1, 6'd1);
      5'd11:   r = mk_op(1'b1, 1'b0, POLY_ACC, 3'd5, 6'd20);
      5'd12:   r = mk_op(1'b0, 1'b0, POLY_ACC, 3'd4, 6'd12);
      5'd13:   r = mk_op(1'b0, 1'b0, POLY_ACC, 3'd3, 6'd6);
      5'd14:   r = mk_op(1'b0, 1'b1, POLY_ACC, 3'd2, 6'd2);
      5'd15:   r = mk_op(1'b1, 1'b0, POLY_JRK, 3'd5, 6'd60);
      5'd16:   r = mk_op(1'b0, 1'b0, POLY_JRK, 3'd4, 6'd24);
      5'd17:   r = mk_op(1'b0, 1'b1, POLY_JRK, 3'd3, 6'd6);
      default: r = mk_op(1'b0, 1'b0, POLY_POS, 3'd0, 6'd0);
    endcase
    return r;
  endfunction

endpackage

/* src/qtg_front.sv */
// Front end of the trajectory generator: accepts ticks and keeps sample time.
// Classifies each tick as wrapping or not and queues it. Uses qtg_pkg.
module qtg_front
  import qtg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             restart,
  input  logic             q_full,
  input  logic [StepW-1:0] time_step,
  input  logic [TimeW-1:0] end_time,
  output logic             q_wr,
  output qtg_item_t        q_item
);

  logic [TimeW-1:0] current_time;
  logic [TimeW-1:0] t;
  logic [TimeW:0]   next_time;

  always_comb begin
    t         = restart ? '0 : current_time;
    next_time = {1'b0, t} + {{(TimeW + 1 - StepW){1'b0}}, time_step};
    q_wr      = push && !q_full;
    q_item.sample_time = t;
    q_item.last        = next_time > {1'b0, end_time};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
    end else if (q_wr) begin
      // wrap to zero once the next step would pass the end time
      current_time <= q_item.last ? '0 : next_time[TimeW-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    q_wr && q_item.last |=> current_time == '0)
    else $error("time did not wrap after last tick");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    q_wr && !q_item.last |=> current_time == $past(next_time[TimeW-1:0]))
    else $error("time did not advance by the step");
`endif

endmodule

/* src/qtg_queue.sv */
// Short queue of classified ticks between the front end and the engine.
// Uses qtg_pkg for the item type.
module qtg_queue
  import qtg_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  qtg_item_t wr_item,
  output logic      full,
  input  logic      rd_en,
  output qtg_item_t rd_item,
  output logic      empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  qtg_item_t       mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = count == CntW'(DEPTH);
  assign empty   = count == '0;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> count < CntW'(DEPTH))
    else $error("write into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> count != '0)
    else $error("read from empty queue");
`endif

endmodule

/* src/qtg_back.sv */
// Evaluation engine: Horner's rule on one shared 32x25 multiplier.
// Evaluates position and three derivatives, then holds the result beat.
// Uses qtg_pkg for the operation table and types.
module qtg_back
  import qtg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  qtg_coef_t               coefs [NumCoefs],
  input  logic                    q_empty,
  input  qtg_item_t               q_item,
  output logic                    q_pop,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic signed [CoefW-1:0] position,
  output logic signed [CoefW-1:0] velocity,
  output logic signed [CoefW-1:0] acceleration,
  output logic signed [CoefW-1:0] jerk,
  output logic [TimeW-1:0]        sample_time,
  output logic                    last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam logic signed [SumW-1:0] SatMax = SumW'(64'sd2147483647);
  localparam logic signed [SumW-1:0] SatMin = -SumW'(64'sd2147483648);

  state_t                    state;
  logic [OpW-1:0]            op;
  logic signed [TermW-1:0]   wc;
  logic signed [TermW-1:0]   wc_next;
  logic signed [CoefW-1:0]   acc;
  logic [TimeW-1:0]          item_time;
  logic                      item_last;
  logic                      out_valid;
  logic signed [CoefW-1:0]   res [4];
  qtg_op_t                   cur;
  qtg_op_t                   sel;
  logic signed [ProdW-1:0]   prod;
  logic signed [ProdW-1:0]   prod_rnd;
  logic signed [SumW-1:0]    wc_ext;
  logic signed [SumW-1:0]    sum;
  logic signed [CoefW-1:0]   sat_val;
  logic                      handoff;

  always_comb begin
    cur = op_info(op);
    // weighted coefficient is prepared one op ahead
    sel = (state == S_IDLE) ? op_info('0) : op_info(op + 1'b1);
    wc_next  = TermW'(coefs[sel.cidx]) * TermW'($signed({1'b0, sel.weight}));
    prod     = ProdW'(acc) * ProdW'($signed({1'b0, item_time}));
    prod_rnd = prod + ProdW'(64'sd32768);
    wc_ext   = {{(SumW - TermW){wc[TermW-1]}}, wc};
    if (cur.init) begin
      sum = wc_ext;
    end else begin
      sum = {prod_rnd[ProdW-1], prod_rnd[ProdW-1:FracW]} + wc_ext;
    end
    if (sum > SatMax) begin
      sat_val = SatMax[CoefW-1:0];
    end else if (sum < SatMin) begin
      sat_val = SatMin[CoefW-1:0];
    end else begin
      sat_val = sum[CoefW-1:0];
    end
  end

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign handoff   = (state == S_DONE) && (!out_valid || out_pop);
  assign out_empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_RUN;
            op    <= '0;
          end
        end
        S_RUN: begin
          if (op == OpW'(NumOps - 1)) begin
            state <= S_DONE;
          end else begin
            op <= op + 1'b1;
          end
        end
        S_DONE: begin
          if (handoff) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (handoff) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_time <= q_item.sample_time;
      item_last <= q_item.last;
    end
    if (q_pop || state == S_RUN) begin
      wc <= wc_next;
    end
    if (state == S_RUN) begin
      acc <= sat_val;
      if (cur.fin) begin
        res[cur.poly] <= sat_val;
      end
    end
    if (handoff) begin
      position     <= res[POLY_POS];
      velocity     <= res[POLY_VEL];
      acceleration <= res[POLY_ACC];
      jerk         <= res[POLY_JRK];
      sample_time  <= item_time;
      last         <= item_last;
    end
  end

`ifndef ASSERT_OFF
  a_op_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> op < OpW'(NumOps))
    else $error("op counter past end of schedule");

  a_handoff: assert property (@(posedge clk) disable iff (rst)
    handoff |=> out_valid && state == S_IDLE)
    else $error("result beat not presented after handoff");
`endif

endmodule

/* src/quintic_trajectory_generator.sv */
// Quintic trajectory generator. Each pushed tick is timed and queued at once
// by the front end while the queue is not full; the engine then loads it, runs
// 18 Horner steps on a single shared 32x25 multiplier (position, velocity,
// acceleration, jerk), and hands the result beat to the output register. The
// engine takes a new tick only after handing off the last one; up to
// QUEUE_DEPTH ticks plus one in the engine and one waiting result may be
// outstanding. Write the configuration registers only while idle.
module quintic_trajectory_generator
  import qtg_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic                    restart,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [CoefW-1:0] position,
  output logic signed [CoefW-1:0] velocity,
  output logic signed [CoefW-1:0] acceleration,
  output logic signed [CoefW-1:0] jerk,
  output logic [TimeW-1:0]        sample_time,
  output logic                    last,
  input  logic                    cfg_write,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [CoefW-1:0]        cfg_data
);

  qtg_coef_t        coefs [NumCoefs];
  logic [StepW-1:0] time_step;
  logic [TimeW-1:0] end_time;
  logic             q_wr;
  logic             q_pop;
  logic             q_empty;
  qtg_item_t        q_wr_item;
  qtg_item_t        q_rd_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCoefs; i++) begin
        coefs[i] <= '0;
      end
      time_step <= StepW'(655);
      end_time  <= TimeW'(262144);
    end else if (cfg_write) begin
      case (qtg_reg_e'(cfg_index))
        REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3, REG_COEF_4, REG_COEF_5: begin
          coefs[cfg_index] <= cfg_data;
        end
        REG_TIME_STEP: begin
          time_step <= cfg_data[StepW-1:0];
        end
        REG_END_TIME: begin
          end_time <= cfg_data[TimeW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  qtg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .restart   (restart),
    .q_full    (full),
    .time_step (time_step),
    .end_time  (end_time),
    .q_wr      (q_wr),
    .q_item    (q_wr_item)
  );

  qtg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_item (q_wr_item),
    .full    (full),
    .rd_en   (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  qtg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .coefs        (coefs),
    .q_empty      (q_empty),
    .q_item       (q_rd_item),
    .q_pop        (q_pop),
    .out_empty    (empty),
    .out_pop      (pop),
    .position     (position),
    .velocity     (velocity),
    .acceleration (acceleration),
    .jerk         (jerk),
    .sample_time  (sample_time),
    .last         (last)
  );

endmodule

/* dv/tb.sv */
// Self-checking testbench for quintic_trajectory_generator: queued tick driver,
// result monitor and a cycle-free predictor of the saturating Horner evaluation.
// Depends on src/qtg_pkg.sv and src/quintic_trajectory_generator.sv.
`timescale 1ns / 1ps

module tb
  import qtg_pkg::*;
();

  typedef struct packed {
    logic [CoefW-1:0] position;
    logic [CoefW-1:0] velocity;
    logic [CoefW-1:0] acceleration;
    logic [CoefW-1:0] jerk;
    logic [TimeW-1:0] sample_time;
    logic             last;
  } motion_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    push = 1'b0;
  logic                    full;
  logic                    restart = 1'b0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic signed [CoefW-1:0] position;
  logic signed [CoefW-1:0] velocity;
  logic signed [CoefW-1:0] acceleration;
  logic signed [CoefW-1:0] jerk;
  logic [TimeW-1:0]        sample_time;
  logic                    last;
  logic                    cfg_write = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index = '0;
  logic [CoefW-1:0]        cfg_data = '0;

  // predictor copy of the registers and the tick clock
  longint coef_q[NumCoefs] = '{0, 0, 0, 0, 0, 0};
  longint step_q = 655;
  longint end_q = 262144;
  longint now_time = 0;

  bit      pending_ticks[$];
  motion_t motion_q[$];
  int      errors = 0;
  int      send_gap = 0;
  int      send_burst = 0;
  int      recv_gap = 0;
  int      recv_burst = 0;

  quintic_trajectory_generator DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .restart      (restart),
    .empty        (empty),
    .pop          (pop),
    .position     (position),
    .velocity     (velocity),
    .acceleration (acceleration),
    .jerk         (jerk),
    .sample_time  (sample_time),
    .last         (last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // d-th derivative by Horner, saturating after every step
  function automatic longint deriv_at(int d, longint t);
    longint acc;
    longint w;
    int i;
    int k;
    acc = 0;
    for (i = NumCoefs - 1; i >= d; i--) begin
      w = 1;
      for (k = 0; k < d; k++) w = w * (i - k);
      if (i == NumCoefs - 1) acc = clamp32(w * coef_q[i]);
      else acc = clamp32(((acc * t + 32768) >>> FracW) + w * coef_q[i]);
    end
    return acc;
  endfunction

  task automatic predict_tick(logic rs);
    motion_t m;
    longint t;
    longint nxt;
    if (rs) now_time = 0;
    t = now_time;
    m.position     = CoefW'(deriv_at(0, t));
    m.velocity     = CoefW'(deriv_at(1, t));
    m.acceleration = CoefW'(deriv_at(2, t));
    m.jerk         = CoefW'(deriv_at(3, t));
    m.sample_time  = TimeW'(t);
    nxt = t + step_q;
    m.last = nxt > end_q;
    now_time = m.last ? 0 : (nxt & 64'hFFFFFF);
    motion_q.push_back(m);
  endtask

  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  task automatic report(string what, logic [CoefW-1:0] got, logic [CoefW-1:0] want);
    errors++;
    $display("%0t %s: got %h expected %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin : drive_ticks
    logic go;
    if (rst) begin
      push <= 1'b0;
    end else begin
      go = push;
      if (push && !full) begin
        predict_tick(restart);
        go = 1'b0;
        send_gap = draw_wait(send_burst);
      end
      if (!go && pending_ticks.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else begin
          restart <= pending_ticks.pop_front();
          go = 1'b1;
        end
      end
      push <= go;
    end
  end

  always @(posedge clk) begin : check_results
    logic    want;
    motion_t m;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      want = pop;
      if (pop && !empty) begin
        if (motion_q.size() == 0) begin
          report("result beat with nothing expected", position, '0);
        end else begin
          m = motion_q.pop_front();
          if (position !== m.position) report("position", position, m.position);
          if (velocity !== m.velocity) report("velocity", velocity, m.velocity);
          if (acceleration !== m.acceleration)
            report("acceleration", acceleration, m.acceleration);
          if (jerk !== m.jerk) report("jerk", jerk, m.jerk);
          if (sample_time !== m.sample_time)
            report("sample_time", CoefW'(sample_time), CoefW'(m.sample_time));
          if (last !== m.last) report("last", CoefW'(last), CoefW'(m.last));
        end
        want = 1'b0;
        recv_gap = draw_wait(recv_burst);
      end
      if (!want) begin
        if (recv_gap > 0) recv_gap--;
        else want = 1'b1;
      end
      pop <= want;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || push || motion_q.size() != 0);
  endtask

  task automatic write_reg(qtg_reg_e idx, logic [CoefW-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_TIME_STEP: step_q = longint'(data[StepW-1:0]);
      REG_END_TIME:  end_q = longint'(data[TimeW-1:0]);
      default:       coef_q[int'(idx)] = longint'($signed(data));
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_ticks(int n, int odds);
    int i;
    for (i = 0; i < n; i++) pending_ticks.push_back($urandom_range(0, odds - 1) == 0);
    wait_idle();
  endtask

  function automatic logic [CoefW-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      2: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      3: return '0;
      4: return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [CoefW-1:0] rand_step();
    logic [CoefW-1:0] d;
    d = $urandom;
    case ($urandom_range(0, 7))
      0, 1, 2: d[StepW-1:0] = StepW'($urandom_range(1, 16'h0800));
      3, 4:    d[StepW-1:0] = StepW'($urandom_range(1, 16'hFFFF));
      5:       d[StepW-1:0] = 16'hFFFF;
      6:       d[StepW-1:0] = 16'h0001;
      default: d[StepW-1:0] = '0;
    endcase
    return d;
  endfunction

  function automatic logic [CoefW-1:0] rand_end();
    logic [CoefW-1:0] d;
    d = $urandom;
    case ($urandom_range(0, 4))
      0, 1: d[TimeW-1:0] = TimeW'($urandom_range(1, 24'h04_0000));
      2:    d[TimeW-1:0] = TimeW'($urandom_range(0, 24'hFF_FFFF));
      3:    d[TimeW-1:0] = 24'hFF_FFFF;
      default: d[TimeW-1:0] = TimeW'($urandom_range(0, 24'h00_0400));
    endcase
    return d;
  endfunction

  initial begin
    int i;
    int p;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset profile: all zero coefficients
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b1);
    pending_ticks.push_back(1'b0);
    wait_idle();

    // full-scale coefficients and widest timing: drive saturation both ways
    for (i = 0; i < NumCoefs; i++) write_reg(qtg_reg_e'(REG_COEF_0 + i), 32'h7FFF_FFFF);
    write_reg(REG_TIME_STEP, 32'h0000_FFFF);
    write_reg(REG_END_TIME, 32'h00FF_FFFF);
    run_ticks(3, 1000000);
    for (i = 0; i < NumCoefs; i++) write_reg(qtg_reg_e'(REG_COEF_0 + i), 32'h8000_0000);
    pending_ticks.push_back(1'b1);
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b0);
    wait_idle();

    // end time lowered below the running time: evaluate, mark last, wrap
    write_reg(REG_COEF_0, 32'h0100_0000);
    write_reg(REG_COEF_1, 32'hFF00_0000);
    write_reg(REG_COEF_2, 32'h0080_0000);
    write_reg(REG_COEF_3, 32'h0010_0000);
    write_reg(REG_COEF_4, 32'hFFF0_0000);
    write_reg(REG_COEF_5, 32'h0001_0000);
    write_reg(REG_TIME_STEP, 32'hFFFF_8000);
    pending_ticks.push_back(1'b1);
    run_ticks(2, 1000000);
    write_reg(REG_END_TIME, 32'hFF00_0100);
    run_ticks(2, 1000000);

    // zero step holds time at zero
    write_reg(REG_TIME_STEP, 32'hABCD_0000);
    run_ticks(2, 1000000);

    // zero step with time already past the end still wraps once
    write_reg(REG_END_TIME, 32'h00FF_FFFF);
    write_reg(REG_TIME_STEP, 32'h0000_8000);
    run_ticks(1, 1000000);
    write_reg(REG_TIME_STEP, 32'h0000_0000);
    write_reg(REG_END_TIME, 32'h0000_0100);
    run_ticks(2, 1000000);

    // zero end time: every beat is last
    write_reg(REG_END_TIME, 32'h5A00_0000);
    write_reg(REG_TIME_STEP, 32'h0000_028F);
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b1);
    wait_idle();

    for (p = 0; p < 12; p++) begin
      for (i = 0; i < NumCoefs; i++) write_reg(qtg_reg_e'(REG_COEF_0 + i), rand_coef());
      write_reg(REG_TIME_STEP, rand_step());
      write_reg(REG_END_TIME, rand_end());
      case ($urandom_range(0, 2))
        0:       run_ticks($urandom_range(110, 140), 2);
        1:       run_ticks($urandom_range(110, 140), 8);
        default: run_ticks($urandom_range(110, 140), 64);
      endcase
    end

    // let any stray beat show up before judging
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

/* sim.f */
src/qtg_pkg.sv
src/qtg_front.sv
src/qtg_queue.sv
src/qtg_back.sv
src/quintic_trajectory_generator.sv
dv/tb.sv
